@@ src/rtt_pkg.sv @@
`default_nettype none

package rtt_pkg;

  localparam int ID_W        = 32;
  localparam int DUR_W       = 32;
  localparam int TIME_W      = 48;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;
  localparam int DEF_SLOTS   = 16;
  localparam int MAX_RESULTS = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CREATED   = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_TICK      = 3'd4
  } status_t;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] expiry;
    logic [DUR_W-1:0]  period;
    logic              repeats;
  } entry_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                 input logic [DUR_W-1:0]  d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W+1-DUR_W){1'b0}}, d};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/repeating_timer_table_unit.sv @@
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  op, timer_id, duration_ms, schedule_time,
//                                          repeat_req, now_ms
// out_      output     out_valid/out_stall status, fired, fired_id, last
//
// One item is worked on at a time. A create writes its slot when it is taken, then waits for the output register.
// Delete and tick walk the slot memory one slot per cycle when not stalled, a rate set
// by the single read port of the slot memory, whose read data is registered.
// A tick with several expired timers stalls its walk while the output register is full.
// Reset empties the table at once (valid bit per slot); entry contents are not cleared.
// The next item is taken while the final result still waits in the output register.

module repeating_timer_table_unit #(
  parameter int SLOTS = rtt_pkg::DEF_SLOTS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [rtt_pkg::OP_W-1:0]    in_op,
  input  wire logic [rtt_pkg::ID_W-1:0]    in_timer_id,
  input  wire logic [rtt_pkg::DUR_W-1:0]   in_duration_ms,
  input  wire logic [rtt_pkg::TIME_W-1:0]  in_schedule_time,
  input  wire logic                        in_repeat_req,
  input  wire logic [rtt_pkg::TIME_W-1:0]  in_now_ms,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rtt_pkg::STATUS_W-1:0]     out_status,
  output logic                             out_fired,
  output logic [rtt_pkg::ID_W-1:0]         out_fired_id,
  output logic                             out_last
);
  import rtt_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] LAST_FIRE = CNT_W'(MAX_RESULTS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SLOTS-1:0]    used_r, used_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt, rd_addr;
  logic                is_tick_r, is_tick_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [ID_W-1:0]     key_r, key_nxt;
  status_t             resp_r, resp_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]     pend_id_r, pend_id_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;

  entry_t              slot_mem [SLOTS];
  entry_t              rd_data_r;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_fired_r, out_last_r;
  logic [ID_W-1:0]     out_fired_id_r;

  logic                emit, emit_fired, emit_last, adv;
  status_t             emit_status;
  logic [ID_W-1:0]     emit_id;

  logic                in_fire, out_free;
  logic                free_hit;
  logic [IDX_W-1:0]    free_idx;
  logic                cur_used, expired, id_match, at_end;

  assign in_stall     = (state_r != S_IDLE);
  assign in_fire      = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_fired    = out_fired_r;
  assign out_fired_id = out_fired_id_r;
  assign out_last     = out_last_r;

  // lowest free slot
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign cur_used = used_r[idx_r];
  assign expired  = cur_used && (now_r >= rd_data_r.expiry);
  assign id_match = cur_used && (rd_data_r.id == key_r);
  assign at_end   = (idx_r == LAST_IDX);

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    idx_nxt        = idx_r;
    is_tick_nxt    = is_tick_r;
    now_nxt        = now_r;
    key_nxt        = key_r;
    resp_nxt       = resp_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    n_nxt          = n_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data_r;
    adv            = 1'b0;
    emit           = 1'b0;
    emit_status    = ST_TICK;
    emit_fired     = 1'b0;
    emit_id        = '0;
    emit_last      = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          idx_nxt = '0;
          case (op_t'(in_op))
            OP_CREATE: begin
              if (free_hit) begin
                used_nxt[free_idx] = 1'b1;
                wr_en              = 1'b1;
                wr_addr            = free_idx;
                wr_data.id         = in_timer_id;
                wr_data.expiry     = sat_add(in_schedule_time, in_duration_ms);
                wr_data.period     = in_duration_ms;
                wr_data.repeats    = in_repeat_req;
                resp_nxt           = ST_CREATED;
              end else begin
                resp_nxt = ST_FULL;
              end
              state_nxt = S_RESP;
            end
            OP_DELETE: begin
              key_nxt     = in_timer_id;
              is_tick_nxt = 1'b0;
              state_nxt   = S_SCAN;
            end
            OP_TICK: begin
              now_nxt        = in_now_ms;
              is_tick_nxt    = 1'b1;
              n_nxt          = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_SCAN;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (is_tick_r) begin
          if (expired) begin
            // a held hit goes out only once a newer one proves it is not the last
            if (!pend_valid_r || out_free) begin
              if (pend_valid_r) begin
                emit       = 1'b1;
                emit_fired = 1'b1;
                emit_id    = pend_id_r;
                emit_last  = 1'b0;
              end
              pend_valid_nxt = 1'b1;
              pend_id_nxt    = rd_data_r.id;
              n_nxt          = n_r + 1'b1;
              if (rd_data_r.repeats) begin
                wr_en          = 1'b1;
                wr_data.expiry = sat_add(now_r, rd_data_r.period);
              end else begin
                used_nxt[idx_r] = 1'b0;
              end
              if (at_end || n_r == LAST_FIRE) state_nxt = S_FLUSH;
              else                            adv = 1'b1;
            end
          end else if (at_end) begin
            state_nxt = S_FLUSH;
          end else begin
            adv = 1'b1;
          end
        end else begin
          if (id_match) begin
            used_nxt[idx_r] = 1'b0;
            resp_nxt        = ST_DELETED;
            state_nxt       = S_RESP;
          end else if (at_end) begin
            resp_nxt  = ST_NOT_FOUND;
            state_nxt = S_RESP;
          end else begin
            adv = 1'b1;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_status    = ST_TICK;
          emit_fired     = pend_valid_r;
          emit_id        = pend_valid_r ? pend_id_r : '0;
          emit_last      = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      S_RESP: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = resp_r;
          state_nxt   = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (adv) idx_nxt = idx_r + 1'b1;
  end

  // read the slot that is evaluated next cycle; a stalled walk re-reads its slot
  always_comb begin
    if (state_r == S_IDLE) rd_addr = '0;
    else if (adv)          rd_addr = idx_r + 1'b1;
    else                   rd_addr = idx_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) slot_mem[wr_addr] <= wr_data;
    rd_data_r <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
      n_r          <= '0;
      is_tick_r    <= 1'b0;
      resp_r       <= ST_CREATED;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      pend_valid_r <= pend_valid_nxt;
      idx_r        <= idx_nxt;
      n_r          <= n_nxt;
      is_tick_r    <= is_tick_nxt;
      resp_r       <= resp_nxt;
      if (emit)            out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    key_r     <= key_nxt;
    pend_id_r <= pend_id_nxt;
    if (emit) begin
      out_status_r   <= emit_status;
      out_fired_r    <= emit_fired;
      out_fired_id_r <= emit_id;
      out_last_r     <= emit_last;
    end
  end

  a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == S_SCAN || state_r == S_FLUSH))
    else $error("held tick result outside a tick walk");

  a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_RESULTS))
    else $error("tick fired more timers than allowed");

  a_create_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == OP_CREATE && free_hit)
      |=> $countones(used_r) == $past($countones(used_r)) + 1)
    else $error("create did not take exactly one slot");

  a_fired_is_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fired_r) |-> out_status_r == ST_TICK)
    else $error("fired result without tick status");

endmodule

`default_nettype wire
